@@ rtl/fcr_pkg.sv @@
// shared constants and types for the convolution reverb fir block
`default_nettype none

package fcr_pkg;

  // default sizes
  localparam int TapsDef       = 2048;
  localparam int SampleBitsDef = 24;
  localparam int CoefBitsDef   = 24;

  // fixed field and datapath widths
  localparam int IndexBits = 11;
  localparam int AccBits   = 64;

  // item kinds carried in func
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  // one tap read issued to the mac datapath
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } issue_t;

endpackage

`default_nettype wire

@@ rtl/fcr_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module fcr_ram #(
  parameter int Width = 8,
  parameter int Depth = 2,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/fcr_seq.sv @@
// sequencer: input handshake, memory clear, delay line writes and tap address walk
`default_nettype none

module fcr_seq #(
  parameter int TAPS        = fcr_pkg::TapsDef,
  parameter int SAMPLE_BITS = fcr_pkg::SampleBitsDef,
  parameter int COEF_BITS   = fcr_pkg::CoefBitsDef,
  localparam int AddrW = $clog2(TAPS)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           func_i,
  input  wire logic signed [SAMPLE_BITS-1:0]  left_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0]  right_sample_i,
  input  wire logic [fcr_pkg::IndexBits-1:0]  coef_index_i,
  input  wire logic signed [COEF_BITS-1:0]    coef_value_i,
  output logic                                dly_we_o,
  output logic [AddrW-1:0]                    dly_waddr_o,
  output logic [SAMPLE_BITS:0]                dly_wdata_o,
  output logic [AddrW-1:0]                    dly_raddr_o,
  output logic                                coef_we_o,
  output logic [AddrW-1:0]                    coef_waddr_o,
  output logic [COEF_BITS-1:0]                coef_wdata_o,
  output logic [AddrW-1:0]                    coef_raddr_o,
  output fcr_pkg::issue_t                     issue_o,
  input  wire logic                           done_i
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(TAPS - 1);

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] wp_q, wp_d;
  logic [AddrW-1:0] tap_q, tap_d;
  logic [AddrW-1:0] pos_q, pos_d;

  logic                 accept;
  logic                 clearing;
  logic                 coef_in_range;
  logic                 tap_last;
  logic [SAMPLE_BITS:0] sum;

  assign in_stall_o    = (state_q != S_IDLE);
  assign accept        = in_valid_i && !in_stall_o;
  assign clearing      = (state_q == S_CLEAR);
  assign coef_in_range = (32'(coef_index_i) < 32'(TAPS));
  assign tap_last      = (tap_q == LastAddr);

  // stereo sum is exact one bit wider
  assign sum = {left_sample_i[SAMPLE_BITS-1], left_sample_i}
             + {right_sample_i[SAMPLE_BITS-1], right_sample_i};

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    wp_d    = wp_q;
    tap_d   = tap_q;
    pos_d   = pos_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && (func_i == fcr_pkg::FUNC_SAMPLE)) begin
          state_d = S_RUN;
          tap_d   = '0;
          pos_d   = wp_q;
          wp_d    = (wp_q == LastAddr) ? '0 : wp_q + 1'b1;
        end
      end
      S_RUN: begin
        tap_d = tap_q + 1'b1;
        // walk the delay line backwards from the newest entry
        pos_d = (pos_q == '0) ? LastAddr : pos_q - 1'b1;
        if (tap_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (done_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      wp_q    <= '0;
      tap_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wp_q    <= wp_d;
      tap_q   <= tap_d;
      pos_q   <= pos_d;
    end
  end

  assign dly_we_o    = clearing || (accept && (func_i == fcr_pkg::FUNC_SAMPLE));
  assign dly_waddr_o = clearing ? clr_q : wp_q;
  assign dly_wdata_o = clearing ? '0 : sum;
  assign dly_raddr_o = pos_q;

  assign coef_we_o    = clearing || (accept && (func_i == fcr_pkg::FUNC_COEF) && coef_in_range);
  assign coef_waddr_o = clearing ? clr_q : AddrW'(coef_index_i);
  assign coef_wdata_o = clearing ? '0 : coef_value_i;
  assign coef_raddr_o = tap_q;

  assign issue_o.valid = (state_q == S_RUN);
  assign issue_o.first = (state_q == S_RUN) && (tap_q == '0);
  assign issue_o.last  = (state_q == S_RUN) && tap_last;

`ifndef SYNTHESIS
  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (state_q == S_DRAIN))
    else $error("result handed off outside drain");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (32'(pos_q) < 32'(TAPS)))
    else $error("delay read address out of range");

  a_first_on_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == fcr_pkg::FUNC_SAMPLE)) |=> issue_o.first)
    else $error("tap walk did not start at tap zero");
`endif

endmodule

`default_nettype wire

@@ rtl/fcr_mac.sv @@
// mac datapath: multiply, accumulate, round, saturate and output register
`default_nettype none

module fcr_mac #(
  parameter int SAMPLE_BITS = fcr_pkg::SampleBitsDef,
  parameter int COEF_BITS   = fcr_pkg::CoefBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fcr_pkg::issue_t               issue_i,
  input  wire logic [SAMPLE_BITS:0]          dly_rdata_i,
  input  wire logic [COEF_BITS-1:0]          coef_rdata_i,
  output logic                               done_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_o
);

  localparam int AccW  = fcr_pkg::AccBits;
  localparam int ProdW = SAMPLE_BITS + 1 + COEF_BITS;

  localparam logic signed [AccW-1:0] Half   = AccW'(1) << (COEF_BITS - 2);
  localparam logic signed [AccW-1:0] SatMax = (AccW'(1) << (SAMPLE_BITS - 1)) - AccW'(1);
  localparam logic signed [AccW-1:0] SatMin = ~SatMax;

  // read data stage flags
  logic v1_q, f1_q, l1_q;
  // product stage
  logic v2_q, f2_q, l2_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  prod_ext;
  // accumulate and finish
  logic signed [AccW-1:0]  acc_q;
  logic                    fin_q;
  logic signed [AccW-1:0]  rnd_q;
  logic                    pend_q;
  logic                    load;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                    out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  generate
    if (ProdW >= AccW) begin : g_trunc
      assign prod_ext = prod_q[AccW-1:0];
    end else begin : g_sext
      assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    end
  endgenerate

  always_comb begin
    if (rnd_q > SatMax) begin
      sat = SatMax[SAMPLE_BITS-1:0];
    end else if (rnd_q < SatMin) begin
      sat = SatMin[SAMPLE_BITS-1:0];
    end else begin
      sat = rnd_q[SAMPLE_BITS-1:0];
    end
  end

  // the finished result waits in rnd_q until the output slot frees
  assign load = pend_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(dly_rdata_i) * $signed(coef_rdata_i);
    if (v2_q) begin
      acc_q <= (f2_q ? '0 : acc_q) + prod_ext;
    end
    if (fin_q) begin
      rnd_q <= (acc_q + Half) >>> (COEF_BITS - 1);
    end
    if (load) begin
      out_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      f1_q        <= 1'b0;
      l1_q        <= 1'b0;
      v2_q        <= 1'b0;
      f2_q        <= 1'b0;
      l2_q        <= 1'b0;
      fin_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q  <= issue_i.valid;
      f1_q  <= issue_i.first;
      l1_q  <= issue_i.last;
      v2_q  <= v1_q;
      f2_q  <= f1_q;
      l2_q  <= l1_q;
      fin_q <= v2_q && l2_q;
      if (fin_q) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign done_o       = load;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

endmodule

`default_nettype wire

@@ rtl/fir_convolution_reverb.sv @@
// top level of the convolution reverb fir filter
//
//   channel | valid     | stall       | payload
//   --------+-----------+-------------+------------------------------------------------
//   in      | in_valid_i| in_stall_o  | func_i left_sample_i right_sample_i
//           |           |             | coef_index_i coef_value_i
//   out     | out_valid_o| out_stall_i| out_sample_o
//
// an audio item is filtered with one mac per tap:
// each cycle reads one delay line entry and one coefficient from the two rams
// a coefficient write gives no result
// after reset both rams are cleared while in_stall_o stays high
// a result waiting under out_stall_i does not block the next input transfer;
// only the hand-off of the following result waits for the output slot
`default_nettype none

module fir_convolution_reverb #(
  parameter int TAPS        = fcr_pkg::TapsDef,
  parameter int SAMPLE_BITS = fcr_pkg::SampleBitsDef,
  parameter int COEF_BITS   = fcr_pkg::CoefBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          func_i,
  input  wire logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input  wire logic [fcr_pkg::IndexBits-1:0] coef_index_i,
  input  wire logic signed [COEF_BITS-1:0]   coef_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_o
);

  localparam int AddrW = $clog2(TAPS);

  logic                 dly_we;
  logic [AddrW-1:0]     dly_waddr;
  logic [SAMPLE_BITS:0] dly_wdata;
  logic [AddrW-1:0]     dly_raddr;
  logic [SAMPLE_BITS:0] dly_rdata;
  logic                 coef_we;
  logic [AddrW-1:0]     coef_waddr;
  logic [COEF_BITS-1:0] coef_wdata;
  logic [AddrW-1:0]     coef_raddr;
  logic [COEF_BITS-1:0] coef_rdata;
  fcr_pkg::issue_t      issue;
  logic                 done;

  fcr_seq #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .coef_index_i   (coef_index_i),
    .coef_value_i   (coef_value_i),
    .dly_we_o       (dly_we),
    .dly_waddr_o    (dly_waddr),
    .dly_wdata_o    (dly_wdata),
    .dly_raddr_o    (dly_raddr),
    .coef_we_o      (coef_we),
    .coef_waddr_o   (coef_waddr),
    .coef_wdata_o   (coef_wdata),
    .coef_raddr_o   (coef_raddr),
    .issue_o        (issue),
    .done_i         (done)
  );

  fcr_ram #(
    .Width (SAMPLE_BITS + 1),
    .Depth (TAPS)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (dly_we),
    .waddr_i (dly_waddr),
    .wdata_i (dly_wdata),
    .raddr_i (dly_raddr),
    .rdata_o (dly_rdata)
  );

  fcr_ram #(
    .Width (COEF_BITS),
    .Depth (TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  fcr_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .dly_rdata_i  (dly_rdata),
    .coef_rdata_i (coef_rdata),
    .done_o       (done),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_sample_o (out_sample_o)
  );

endmodule

`default_nettype wire

@@ bench/reverb_checker.sv @@
// checker for the convolution reverb: predicts each mono sample from observed transfers
module reverb_checker #(
  parameter int TAPS        = fcr_pkg::TapsDef,
  parameter int SAMPLE_BITS = fcr_pkg::SampleBitsDef,
  parameter int COEF_BITS   = fcr_pkg::CoefBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire logic                          func_i,
  input  wire logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input  wire logic [fcr_pkg::IndexBits-1:0] coef_index_i,
  input  wire logic signed [COEF_BITS-1:0]   coef_value_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic signed [SAMPLE_BITS-1:0] out_sample_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AddrW = $clog2(TAPS);

  typedef logic signed [fcr_pkg::AccBits-1:0] acc_t;

  logic signed [SAMPLE_BITS:0]   mix_hist [TAPS];
  logic signed [COEF_BITS-1:0]   ir_coef  [TAPS];
  int unsigned                   head;
  logic signed [SAMPLE_BITS-1:0] expected_mono [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // stores the stereo sum, runs the full convolution and returns the clipped sample
  function automatic logic signed [SAMPLE_BITS-1:0] convolve_mix(
    input logic signed [SAMPLE_BITS-1:0] l,
    input logic signed [SAMPLE_BITS-1:0] r
  );
    logic signed [SAMPLE_BITS:0] lw, rw;
    acc_t acc, cw, dw, half, lim_hi, lim_lo;
    int unsigned pos;
    lw = (SAMPLE_BITS+1)'(l);
    rw = (SAMPLE_BITS+1)'(r);
    mix_hist[head[AddrW-1:0]] = lw + rw;
    acc = '0;
    for (int unsigned k = 0; k < TAPS; k++) begin
      pos = (head >= k) ? head - k : head + TAPS - k;
      cw  = acc_t'(ir_coef[k[AddrW-1:0]]);
      dw  = acc_t'(mix_hist[pos[AddrW-1:0]]);
      acc = acc + cw * dw;
    end
    // round half up, then back to sample scale
    half = 1;
    half = half <<< (COEF_BITS - 2);
    acc  = (acc + half) >>> (COEF_BITS - 1);
    lim_hi = 1;
    lim_hi = (lim_hi <<< (SAMPLE_BITS - 1)) - 1;
    lim_lo = -lim_hi - 1;
    if (acc > lim_hi) begin
      acc = lim_hi;
    end else if (acc < lim_lo) begin
      acc = lim_lo;
    end
    head = (head + 1 >= TAPS) ? 0 : head + 1;
    return acc[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [SAMPLE_BITS-1:0] want;
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        mix_hist[k[AddrW-1:0]] = '0;
        ir_coef[k[AddrW-1:0]]  = '0;
      end
      head = 0;
      expected_mono.delete();
      pending_o = 0;
    end else begin
      // results first, so a result never matches an item accepted at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_mono.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: out_sample %0d arrived with nothing expected", $time, out_sample_i);
          end
        end else begin
          want = expected_mono.pop_front();
          if (out_sample_i !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: out_sample expected %0d got %0d", $time, want, out_sample_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (func_i == fcr_pkg::FUNC_COEF) begin
          if (coef_index_i < TAPS) begin
            ir_coef[AddrW'(coef_index_i)] = coef_value_i;
          end
        end else begin
          expected_mono.push_back(convolve_mix(left_sample_i, right_sample_i));
        end
      end
      pending_o = expected_mono.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
// top of the convolution reverb bench: stimulus, output stall, verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Taps = fcr_pkg::TapsDef;
  localparam int SB   = fcr_pkg::SampleBitsDef;
  localparam int CB   = fcr_pkg::CoefBitsDef;
  localparam int IB   = fcr_pkg::IndexBits;

  localparam logic signed [SB-1:0] SMAX     = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN     = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [CB-1:0] CMAX     = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN     = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] CHALF    = CB'(1 <<< (CB - 2));
  // two of these summed against a unit coefficient land exactly on the rounding edge
  localparam logic signed [SB-1:0] RND_EDGE = SB'(1 <<< (CB - 3));
  localparam int unsigned          IDX_TOP  = (1 << IB) - 1;

  typedef struct {
    logic                 func;
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic [IB-1:0]        idx;
    logic signed [CB-1:0] coef;
  } reverb_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 func;
  logic signed [SB-1:0] left_sample;
  logic signed [SB-1:0] right_sample;
  logic [IB-1:0]        coef_index;
  logic signed [CB-1:0] coef_value;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [SB-1:0] out_sample;
  int                   fail_count;
  int                   pending;
  bit                   calm = 1'b0;
  int                   stall_left = 0;

  fir_convolution_reverb #(
    .TAPS       (Taps),
    .SAMPLE_BITS(SB),
    .COEF_BITS  (CB)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func),
    .left_sample_i (left_sample),
    .right_sample_i(right_sample),
    .coef_index_i  (coef_index),
    .coef_value_i  (coef_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_sample_o  (out_sample)
  );

  reverb_checker #(
    .TAPS       (Taps),
    .SAMPLE_BITS(SB),
    .COEF_BITS  (CB)
  ) reverb_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .func_i        (func),
    .left_sample_i (left_sample),
    .right_sample_i(right_sample),
    .coef_index_i  (coef_index),
    .coef_value_i  (coef_value),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_sample_i  (out_sample),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #6 clk = ~clk;

  // output side stalls in bursts of random length
  always @(negedge clk) begin
    if (calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(7) == 0) begin
      stall_left = $urandom_range(12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic reverb_item_t audio(input logic signed [SB-1:0] l,
                                         input logic signed [SB-1:0] r);
    reverb_item_t it;
    it.func  = fcr_pkg::FUNC_SAMPLE;
    it.left  = l;
    it.right = r;
    it.idx   = IB'($urandom);
    it.coef  = CB'($urandom);
    return it;
  endfunction

  function automatic reverb_item_t tap_write(input int unsigned idx,
                                             input logic signed [CB-1:0] c);
    reverb_item_t it;
    it.func  = fcr_pkg::FUNC_COEF;
    it.left  = SB'($urandom);
    it.right = SB'($urandom);
    it.idx   = IB'(idx);
    it.coef  = c;
    return it;
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    logic signed [SB-1:0] v;
    case ($urandom_range(7))
      0:       v = SMAX;
      1:       v = SMIN;
      2:       v = SB'(int'($urandom_range(511)) - 256);
      default: v = SB'($urandom);
    endcase
    return v;
  endfunction

  task automatic push_item(input reverb_item_t it);
    @(negedge clk);
    in_valid     <= 1'b1;
    func         <= it.func;
    left_sample  <= it.left;
    right_sample <= it.right;
    coef_index   <= it.idx;
    coef_value   <= it.coef;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic hold_off(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic signed [CB-1:0] cv;
    in_valid     = 1'b0;
    func         = fcr_pkg::FUNC_SAMPLE;
    left_sample  = '0;
    right_sample = '0;
    coef_index   = '0;
    coef_value   = '0;
    rst_n        = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // empty coefficient store gives silence
    push_item(audio(SMAX, SMAX));
    push_item(tap_write(0, CMAX));
    // full-scale sums clip both ways
    push_item(audio(SMAX, SMAX));
    push_item(audio(SMIN, SMIN));
    push_item(tap_write(IDX_TOP, CMIN));
    push_item(tap_write(1, CHALF));
    push_item(audio(1, 0));
    push_item(audio(SMAX, SMIN));
    push_item(tap_write(0, CMIN));
    push_item(audio(SMIN, SMIN));
    // unit coefficient on tap 0 and tap 1 cleared, to hit the rounding edge from both sides
    push_item(tap_write(0, 1));
    push_item(tap_write(1, 0));
    push_item(audio(RND_EDGE, RND_EDGE));
    push_item(audio(-RND_EDGE, -RND_EDGE));
    push_item(tap_write(IDX_TOP / 2, CMAX));
    push_item(audio(0, 0));
    push_item(audio(SMIN, SMAX));
    drain();

    for (int n = 0; n < 273; n++) begin
      calm = (n >= 240) || (n >= 110 && n < 130);
      if (n == 170) begin
        drain();
      end
      if (!calm && $urandom_range(2) == 0) begin
        hold_off($urandom_range(1, 13));
      end
      if ($urandom_range(2) == 0) begin
        cv = CB'($urandom);
        case ($urandom_range(9))
          0:       cv = CMAX;
          1:       cv = CMIN;
          2:       cv = '0;
          default: cv = cv >>> $urandom_range(12);
        endcase
        // most writes land on taps that already see written history
        push_item(tap_write($urandom_range(3) == 0 ? $urandom_range(IDX_TOP)
                                                   : $urandom_range(127), cv));
      end else begin
        push_item(audio(pick_sample(), pick_sample()));
      end
    end

    drain();
    repeat (Taps + 20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ fir_convolution_reverb.f @@
rtl/fcr_pkg.sv
rtl/fcr_ram.sv
rtl/fcr_seq.sv
rtl/fcr_mac.sv
rtl/fir_convolution_reverb.sv
bench/reverb_checker.sv
bench/testbench.sv
